FILE: sv/ast_pkg.sv
package ast_pkg;

   localparam int OFFSET_BITS = 24;
   localparam int LINE_BITS = 16;
   localparam int LENGTH_MAX = 255;
   localparam int LENGTH_BITS = $clog2(LENGTH_MAX + 1);
   localparam int KIND_BITS = 5;
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_BITS = $clog2(QUEUE_DEPTH);

   typedef logic [OFFSET_BITS-1:0] offset_type;
   typedef logic [LINE_BITS-1:0] line_type;
   typedef logic [LENGTH_BITS-1:0] length_type;
   typedef logic [KIND_BITS-1:0] kind_type;

   localparam line_type LINE_MAX = '1;
   localparam length_type LENGTH_LIMIT = LENGTH_BITS'(LENGTH_MAX);

   localparam kind_type KIND_EOF = 5'd0;
   localparam kind_type KIND_EOL = 5'd1;
   localparam kind_type KIND_STRING = 5'd2;
   localparam kind_type KIND_NUMBER = 5'd3;
   localparam kind_type KIND_IDENT = 5'd4;
   localparam kind_type KIND_DIRECTIVE = 5'd5;
   localparam kind_type KIND_PLUS = 5'd6;
   localparam kind_type KIND_MINUS = 5'd7;
   localparam kind_type KIND_STAR = 5'd8;
   localparam kind_type KIND_SLASH = 5'd9;
   localparam kind_type KIND_COLON = 5'd10;
   localparam kind_type KIND_COMMA = 5'd11;
   localparam kind_type KIND_LPAREN = 5'd12;
   localparam kind_type KIND_RPAREN = 5'd13;
   localparam kind_type KIND_LBRACKET = 5'd14;
   localparam kind_type KIND_RBRACKET = 5'd15;
   localparam kind_type KIND_DOLLAR = 5'd16;
   localparam kind_type KIND_UNKNOWN = 5'd17;

   localparam logic [7:0] CHAR_TAB_END = 8'd32;
   localparam logic [7:0] CHAR_LF = 8'h0A;
   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_SEMI = 8'h3B;
   localparam logic [7:0] CHAR_DOT = 8'h2E;
   localparam logic [7:0] CHAR_AT = 8'h40;
   localparam logic [7:0] CHAR_QUESTION = 8'h3F;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;
   localparam logic [7:0] CHAR_APOSTROPHE = 8'h27;
   localparam logic [7:0] CHAR_DQUOTE = 8'h22;

   typedef enum logic [2:0] {
      MODE_IDLE,
      MODE_IDENT,
      MODE_NUMBER,
      MODE_STRING,
      MODE_COMMENT,
      MODE_AFTER_CR
   } mode_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic is_end;
   } req_type;

   typedef struct packed {
      kind_type token_kind;
      offset_type start_offset;
      line_type start_line;
      line_type start_column;
      length_type text_length;
      logic last_of_run;
   } rsp_type;

   // One accepted byte yields up to two tokens, kept together until the back end splits them.
   typedef struct packed {
      logic [1:0] count;
      rsp_type first;
      rsp_type second;
   } pair_type;

   function automatic kind_type operator_kind(input logic [7:0] b);
      kind_type k;
      case (b)
         8'h2B: k = KIND_PLUS;
         8'h2D: k = KIND_MINUS;
         8'h2A: k = KIND_STAR;
         8'h2F: k = KIND_SLASH;
         8'h3A: k = KIND_COLON;
         8'h2C: k = KIND_COMMA;
         8'h28: k = KIND_LPAREN;
         8'h29: k = KIND_RPAREN;
         8'h5B: k = KIND_LBRACKET;
         8'h5D: k = KIND_RBRACKET;
         8'h24: k = KIND_DOLLAR;
         default: k = KIND_UNKNOWN;
      endcase
      return k;
   endfunction

endpackage

FILE: sv/ast_front.sv
module ast_front
   import ast_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic accept,
   input req_type item,
   output pair_type pair
);

   mode_type mode_ff, mode_in;
   logic dquote_ff, dquote_in;
   logic directive_ff, directive_in;
   offset_type pos_ff, pos_in;
   line_type line_ff, line_in;
   line_type col_ff, col_in;
   offset_type tok_off_ff, tok_off_in;
   line_type tok_line_ff, tok_line_in;
   line_type tok_col_ff, tok_col_in;
   length_type tok_len_ff, tok_len_in;

   logic [7:0] b;
   logic is_lf, is_cr, newline, is_letter, is_digit, ident_start, ident_more;
   logic blank, semi, quote, quote_match, starts_token, emits_single;
   logic flush, restart, grow, second_valid;
   rsp_type pend_tok, cand_tok;
   kind_type pend_kind;

   always_comb begin
      b = item.data_byte;
      is_lf = (b == CHAR_LF);
      is_cr = (b == CHAR_CR);
      newline = is_lf | is_cr;
      is_letter = ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
      is_digit = (b >= 8'h30) && (b <= 8'h39);
      ident_start = is_letter || (b == CHAR_UNDERSCORE) || (b == CHAR_DOT) ||
                    (b == CHAR_AT) || (b == CHAR_QUESTION);
      ident_more = ident_start || is_digit || (b == CHAR_APOSTROPHE);
      blank = (b == CHAR_SPACE) || ((b != 8'd0) && (b < CHAR_TAB_END) && !newline);
      semi = (b == CHAR_SEMI);
      quote = (b == CHAR_APOSTROPHE) || (b == CHAR_DQUOTE);
      quote_match = dquote_ff ? (b == CHAR_DQUOTE) : (b == CHAR_APOSTROPHE);
      starts_token = quote || is_digit || ident_start;
      emits_single = !(blank || semi || starts_token);
   end

   // Next mode and the control decisions for the current byte.
   always_comb begin
      flush = 1'b0;
      restart = 1'b0;
      grow = 1'b0;
      mode_in = mode_ff;
      if (item.is_end) begin
         flush = (mode_ff == MODE_IDENT) || (mode_ff == MODE_NUMBER) ||
                 (mode_ff == MODE_STRING);
         mode_in = MODE_IDLE;
      end else begin
         case (mode_ff)
            MODE_AFTER_CR: begin
               mode_in = MODE_IDLE;
               restart = !is_lf;
            end
            MODE_IDENT: begin
               if (ident_more) begin
                  grow = 1'b1;
               end else begin
                  flush = 1'b1;
                  restart = 1'b1;
               end
            end
            MODE_NUMBER: begin
               if (is_letter || is_digit) begin
                  grow = 1'b1;
               end else begin
                  flush = 1'b1;
                  restart = 1'b1;
               end
            end
            MODE_STRING: begin
               if (quote_match) begin
                  flush = 1'b1;
                  mode_in = MODE_IDLE;
               end else if (!newline) begin
                  grow = 1'b1;
               end else begin
                  flush = 1'b1;
                  restart = 1'b1;
               end
            end
            MODE_COMMENT: begin
               restart = newline;
            end
            default: begin
               restart = 1'b1;
            end
         endcase
         if (restart) begin
            if (semi) begin
               mode_in = MODE_COMMENT;
            end else if (is_cr) begin
               mode_in = MODE_AFTER_CR;
            end else if (quote) begin
               mode_in = MODE_STRING;
            end else if (is_digit) begin
               mode_in = MODE_NUMBER;
            end else if (ident_start) begin
               mode_in = MODE_IDENT;
            end else begin
               mode_in = MODE_IDLE;
            end
         end
      end
   end

   // Tokens produced, position counters and the pending token's fields.
   always_comb begin
      if (mode_ff == MODE_IDENT) begin
         pend_kind = directive_ff ? KIND_DIRECTIVE : KIND_IDENT;
      end else if (mode_ff == MODE_NUMBER) begin
         pend_kind = KIND_NUMBER;
      end else begin
         pend_kind = KIND_STRING;
      end
      pend_tok = '{pend_kind, tok_off_ff, tok_line_ff, tok_col_ff, tok_len_ff, 1'b0};

      if (item.is_end) begin
         cand_tok = '{KIND_EOF, pos_ff, line_ff, col_ff, '0, 1'b0};
      end else if (newline) begin
         cand_tok = '{KIND_EOL, pos_ff, line_ff, col_ff, '0, 1'b0};
      end else begin
         cand_tok = '{operator_kind(b), pos_ff, line_ff, col_ff, length_type'(1), 1'b0};
      end
      second_valid = item.is_end || (restart && emits_single);

      pair = '0;
      if (flush && second_valid) begin
         pair.count = 2'd2;
         pair.first = pend_tok;
         pair.second = cand_tok;
         pair.second.last_of_run = 1'b1;
      end else if (flush) begin
         pair.count = 2'd1;
         pair.first = pend_tok;
         pair.first.last_of_run = 1'b1;
      end else if (second_valid) begin
         pair.count = 2'd1;
         pair.first = cand_tok;
         pair.first.last_of_run = 1'b1;
      end

      pos_in = pos_ff;
      line_in = line_ff;
      col_in = col_ff;
      if (accept && !item.is_end) begin
         // Every source byte is consumed exactly once, whatever the mode.
         pos_in = pos_ff + offset_type'(1);
         if (is_lf) begin
            if (line_ff != LINE_MAX) begin
               line_in = line_ff + line_type'(1);
            end
            col_in = line_type'(1);
         end else if (col_ff != LINE_MAX) begin
            col_in = col_ff + line_type'(1);
         end
      end

      tok_off_in = tok_off_ff;
      tok_line_in = tok_line_ff;
      tok_col_in = tok_col_ff;
      tok_len_in = tok_len_ff;
      dquote_in = dquote_ff;
      directive_in = directive_ff;
      if (accept && !item.is_end && restart && starts_token) begin
         tok_off_in = quote ? (pos_ff + offset_type'(1)) : pos_ff;
         tok_line_in = line_ff;
         tok_col_in = col_ff;
         tok_len_in = quote ? length_type'(0) : length_type'(1);
         if (quote) begin
            dquote_in = (b == CHAR_DQUOTE);
         end
         if (!quote && !is_digit) begin
            directive_in = (b == CHAR_DOT);
         end
      end else if (accept && grow && (tok_len_ff != LENGTH_LIMIT)) begin
         tok_len_in = tok_len_ff + length_type'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         dquote_ff <= 1'b0;
         directive_ff <= 1'b0;
         pos_ff <= '0;
         line_ff <= line_type'(1);
         col_ff <= line_type'(1);
         tok_off_ff <= '0;
         tok_line_ff <= line_type'(1);
         tok_col_ff <= line_type'(1);
         tok_len_ff <= '0;
      end else begin
         if (accept) begin
            mode_ff <= mode_in;
         end
         dquote_ff <= dquote_in;
         directive_ff <= directive_in;
         pos_ff <= pos_in;
         line_ff <= line_in;
         col_ff <= col_in;
         tok_off_ff <= tok_off_in;
         tok_line_ff <= tok_line_in;
         tok_col_ff <= tok_col_in;
         tok_len_ff <= tok_len_in;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      (line_ff != '0) && (col_ff != '0))
      else $error("line or column counter reached zero");

   assert property (@(posedge clock) disable iff (reset)
      accept && item.is_end |=> (mode_ff == MODE_IDLE))
      else $error("end marker did not return the lexer to idle");
`endif

endmodule

FILE: sv/ast_queue.sv
module ast_queue
   import ast_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic push,
   input pair_type push_data,
   output logic full,
   input logic pop,
   output pair_type head,
   output logic empty
);

   pair_type entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_BITS:0] count_ff, count_in;
   logic do_push, do_pop;

   always_comb begin
      full = (count_ff == (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH));
      empty = (count_ff == '0);
      head = entries_ff[rd_ptr_ff];
      do_push = push && !full;
      do_pop = pop && !empty;
      wr_ptr_in = do_push ? (wr_ptr_ff + QUEUE_PTR_BITS'(1)) : wr_ptr_ff;
      rd_ptr_in = do_pop ? (rd_ptr_ff + QUEUE_PTR_BITS'(1)) : rd_ptr_ff;
      count_in = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + (QUEUE_PTR_BITS + 1)'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - (QUEUE_PTR_BITS + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QUEUE_PTR_BITS + 1)'(QUEUE_DEPTH))
      else $error("queue occupancy exceeds its depth");
`endif

endmodule

FILE: sv/ast_back.sv
module ast_back
   import ast_pkg::*;
(
   input logic clock,
   input logic reset,
   input pair_type head,
   input logic head_empty,
   output logic head_pop,
   output rsp_type rsp_data,
   output logic empty,
   input logic pop
);

   pair_type cur_ff, cur_in;
   logic idx_ff, idx_in;
   logic valid_ff, valid_in;
   logic on_last, advance;

   always_comb begin
      on_last = idx_ff || (cur_ff.count != 2'd2);
      advance = !valid_ff || (pop && on_last);
      head_pop = advance && !head_empty;
      cur_in = cur_ff;
      idx_in = idx_ff;
      valid_in = valid_ff;
      if (advance) begin
         cur_in = head;
         idx_in = 1'b0;
         valid_in = !head_empty;
      end else if (pop) begin
         idx_in = 1'b1;
      end
      empty = !valid_ff;
      rsp_data = idx_ff ? cur_ff.second : cur_ff.first;
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         idx_ff <= idx_in;
         valid_ff <= valid_in;
      end
   end

`ifndef SYNTH
   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> (cur_ff.count != 2'd0))
      else $error("output register holds an entry without tokens");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff && idx_ff |-> (cur_ff.count == 2'd2))
      else $error("second token selected from a single-token entry");

   assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> ((idx_ff || (cur_ff.count == 2'd1)) == rsp_data.last_of_run))
      else $error("last-of-run flag does not match the token position");
`endif

endmodule

FILE: sv/assembler_source_tokenizer.sv
// A token passes through a queue entry and the output-stage register before it appears
// on the result ports. Throughput: one byte per cycle while the queue is not full; a byte
// that closes one token and emits another yields two tokens, absorbed by a four-entry
// queue between lexer and output stage. The output stage shows one token per cycle while
// the consumer pops, and sets the drain rate.
// Reset (synchronous, active high) clears lexer mode, counters, queue and output stage.
module assembler_source_tokenizer
   import ast_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic push,
   output logic full,
   input req_type req_data,
   output logic empty,
   input logic pop,
   output rsp_type rsp_data
);

   logic accept;
   pair_type pair;
   pair_type head;
   logic head_empty, head_pop;

   assign accept = push && !full;

   ast_front u_front (
      .clock(clock),
      .reset(reset),
      .accept(accept),
      .item(req_data),
      .pair(pair)
   );

   ast_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(accept && (pair.count != 2'd0)),
      .push_data(pair),
      .full(full),
      .pop(head_pop),
      .head(head),
      .empty(head_empty)
   );

   ast_back u_back (
      .clock(clock),
      .reset(reset),
      .head(head),
      .head_empty(head_empty),
      .head_pop(head_pop),
      .rsp_data(rsp_data),
      .empty(empty),
      .pop(pop)
   );

endmodule
